>>> rtl/khss_pkg.sv
// shared types, codes and crc helper for the key hash server select block
package khss_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

  // number of server slots; the 4-bit slot fields and 5-bit count are sized for this
  localparam int NumSlots = 16;

  // depth of the queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  localparam logic [1:0] OpKeyByte = 2'd0;
  localparam logic [1:0] OpDisable = 2'd1;
  localparam logic [1:0] OpEnable  = 2'd2;

  localparam logic CfgServerCount = 1'b0;
  localparam logic CfgHashMode    = 1'b1;

  // one job handed from front to back: a finished key hash or a live-bit update
  typedef struct packed {
    logic        is_key;
    logic [31:0] hash;
    logic        live_val;
    logic [3:0]  idx;
  } job_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/khss_front.sv
// front: accepts items, folds key bytes into the crc and classifies jobs
module khss_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        op_i,
  input  logic [7:0]        key_byte_i,
  input  logic              last_byte_i,
  input  logic [3:0]        server_index_i,
  input  logic              hash_mode_i,
  output logic              job_push_o,
  output khss_pkg::job_t    job_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_next;
  logic [31:0] crc_out;
  logic        idx_ok;

  assign crc_next = khss_pkg::crc_byte(crc_q, key_byte_i);
  assign crc_out  = ~crc_next;
  assign idx_ok   = (32'(server_index_i) < khss_pkg::NumSlots);

  always_comb begin
    crc_d      = crc_q;
    job_push_o = 1'b0;
    job_o.is_key   = 1'b0;
    job_o.hash     = hash_mode_i ? crc_out : {17'd0, crc_out[30:16]};
    job_o.live_val = (op_i == khss_pkg::OpEnable);
    job_o.idx      = server_index_i;
    if (accept_i) begin
      case (op_i)
        khss_pkg::OpKeyByte: begin
          crc_d = last_byte_i ? khss_pkg::CrcInit : crc_next;
          if (last_byte_i) begin
            job_push_o   = 1'b1;
            job_o.is_key = 1'b1;
          end
        end
        khss_pkg::OpDisable, khss_pkg::OpEnable: begin
          job_push_o = idx_ok;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= khss_pkg::CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

>>> rtl/khss_fifo.sv
// short job queue between front and back
module khss_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  khss_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output khss_pkg::job_t data_o,
  output logic           empty_o
);

  khss_pkg::job_t mem_q [khss_pkg::QDepth];
  logic [khss_pkg::QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [khss_pkg::QPtrW:0]   cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == (khss_pkg::QPtrW + 1)'(khss_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/khss_back.sv
// back: live bits, bit-serial modulo, slot probe and result register
module khss_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     count_i,
  input  logic           job_empty_i,
  input  khss_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           res_pop_i,
  output logic           res_empty_o,
  output logic           found_o,
  output logic [3:0]     chosen_server_o,
  output logic [31:0]    key_hash_o
);

  localparam int SlotW = (khss_pkg::NumSlots > 1) ? $clog2(khss_pkg::NumSlots) : 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDiv   = 2'd1;
  localparam logic [1:0] StProbe = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [khss_pkg::NumSlots-1:0] live_q, live_d;
  logic [31:0]            hash_q, hash_d;
  logic [31:0]            hp_q, hp_d;
  logic [4:0]             cnt_q, cnt_d;
  logic [4:0]             rem_q, rem_d;
  logic [4:0]             bit_q, bit_d;
  logic [4:0]             slot_q, slot_d;
  logic [4:0]             step_q, step_d;
  logic                   fnd_q, fnd_d;
  logic                   out_vld_q, out_vld_d;
  logic                   out_fnd_q, out_fnd_d;
  logic [3:0]             out_slot_q, out_slot_d;
  logic [31:0]            out_hash_q, out_hash_d;

  logic [5:0]  div_ext;
  logic        div_ge;
  logic [4:0]  div_rem;
  logic [4:0]  slot_inc;
  logic        slot_live;
  logic        out_free;

  assign div_ext   = {rem_q, hp_q[bit_q]};
  assign div_ge    = (div_ext >= {1'b0, cnt_q});
  assign div_rem   = div_ge ? 5'(div_ext - {1'b0, cnt_q}) : div_ext[4:0];
  assign slot_inc  = slot_q + 5'd1;
  assign slot_live = live_q[SlotW'(slot_q)];
  assign out_free  = !out_vld_q || res_pop_i;

  assign job_pop_o       = (state_q == StIdle) && !job_empty_i;
  assign res_empty_o     = !out_vld_q;
  assign found_o         = out_fnd_q;
  assign chosen_server_o = out_slot_q;
  assign key_hash_o      = out_hash_q;

  always_comb begin
    state_d    = state_q;
    live_d     = live_q;
    hash_d     = hash_q;
    hp_d       = hp_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    bit_d      = bit_q;
    slot_d     = slot_q;
    step_d     = step_q;
    fnd_d      = fnd_q;
    out_vld_d  = res_pop_i ? 1'b0 : out_vld_q;
    out_fnd_d  = out_fnd_q;
    out_slot_d = out_slot_q;
    out_hash_d = out_hash_q;
    case (state_q)
      StIdle: begin
        if (!job_empty_i) begin
          if (job_i.is_key) begin
            hash_d = job_i.hash;
            // a zero hash probes as one
            hp_d   = (job_i.hash == '0) ? 32'd1 : job_i.hash;
            cnt_d  = count_i;
            rem_d  = '0;
            bit_d  = 5'd31;
            fnd_d  = 1'b0;
            slot_d = '0;
            step_d = '0;
            state_d = (count_i == '0) ? StDone : StDiv;
          end else begin
            live_d[SlotW'(job_i.idx)] = job_i.live_val;
          end
        end
      end
      StDiv: begin
        rem_d = div_rem;
        bit_d = bit_q - 5'd1;
        if (bit_q == '0) begin
          slot_d  = div_rem;
          state_d = StProbe;
        end
      end
      StProbe: begin
        if (slot_live) begin
          fnd_d   = 1'b1;
          state_d = StDone;
        end else if (step_q == 5'(cnt_q - 5'd1)) begin
          slot_d  = '0;
          state_d = StDone;
        end else begin
          step_d = step_q + 5'd1;
          hp_d   = hp_q + 32'd1;
          // probe position wraps at 2^32 before the modulo
          if (hp_q == 32'hFFFFFFFF || slot_inc == cnt_q) begin
            slot_d = '0;
          end else begin
            slot_d = slot_inc;
          end
        end
      end
      StDone: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_fnd_d  = fnd_q;
          out_slot_d = fnd_q ? 4'(slot_q) : 4'd0;
          out_hash_d = hash_q;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      live_q    <= '1;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      live_q    <= live_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q     <= hash_d;
    hp_q       <= hp_d;
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    bit_q      <= bit_d;
    slot_q     <= slot_d;
    step_q     <= step_d;
    fnd_q      <= fnd_d;
    out_fnd_q  <= out_fnd_d;
    out_slot_q <= out_slot_d;
    out_hash_q <= out_hash_d;
  end

endmodule

>>> rtl/key_hash_server_select_core.sv
// top level of the key hash server select block
// usage:
//   items enter through push/full; an item is taken on a clock edge with push high and
//   full low. key bytes fold into a reflected crc-32 in the front at one beat per cycle.
//   disable/enable items set a slot live bit; they travel through the same job queue as
//   finished keys, so a key is always probed against the live bits set before it.
//   each key ends on a byte with last_byte_i set and gives one result beat on the
//   empty/pop side; the result is taken on an edge with pop high and empty low.
// steps and throughput: a finished key leaves the queue in the idle state, runs the
//   bit-serial modulo from the top hash bit down, probes slots until one is live or
//   server_count slots are tried, then loads the result register once it is free; a zero
//   count skips the modulo and probe. a live-bit update is applied in the idle state. the
//   front takes one beat per cycle until the four-entry job queue fills.
// reset: crc back to all ones, every slot live, server_count and hash_mode zero, queue
//   and result register empty. when pop stays low the back holds its finished result,
//   the queue fills and full rises.
// config: cfg_we_i writes register cfg_idx_i (0 server_count, 1 hash_mode); the user
//   must write it only while idle, which the block itself does not enforce.
module key_hash_server_select_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [7:0]  key_byte_i,
  input  logic        last_byte_i,
  input  logic [3:0]  server_index_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [3:0]  chosen_server_o,
  output logic [31:0] key_hash_o
);

  logic [4:0]     server_count_q;
  logic           hash_mode_q;
  logic [4:0]     count_eff;
  logic           accept;
  logic           job_push;
  khss_pkg::job_t job_in;
  khss_pkg::job_t job_out;
  logic           job_pop;
  logic           job_empty;

  assign accept    = push && !full;
  assign count_eff = (32'(server_count_q) > khss_pkg::NumSlots) ?
                     5'(khss_pkg::NumSlots) : server_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_count_q <= '0;
      hash_mode_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        khss_pkg::CfgServerCount: server_count_q <= cfg_data_i;
        khss_pkg::CfgHashMode:    hash_mode_q    <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  khss_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .op_i           (op_i),
    .key_byte_i     (key_byte_i),
    .last_byte_i    (last_byte_i),
    .server_index_i (server_index_i),
    .hash_mode_i    (hash_mode_q),
    .job_push_o     (job_push),
    .job_o          (job_in)
  );

  khss_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  khss_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .count_i         (count_eff),
    .job_empty_i     (job_empty),
    .job_i           (job_out),
    .job_pop_o       (job_pop),
    .res_pop_i       (pop),
    .res_empty_o     (empty),
    .found_o         (found_o),
    .chosen_server_o (chosen_server_o),
    .key_hash_o      (key_hash_o)
  );

endmodule
